// ===== sv/gfadp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfadp_pkg
// Shared types and codes for the GF(2^8) two-parity dot-product engine.
// ----------------------------------------------------------------------------
package gfadp_pkg;

  localparam int unsigned BYTES_PER_WORD = 8;
  localparam int unsigned WORD_W         = 64;
  localparam int unsigned COUNT_W        = 4;

  // action codes
  localparam logic ACT_TABLE_WRITE = 1'b0;
  localparam logic ACT_DATA        = 1'b1;

  // parity select codes
  localparam logic PAR_ONE = 1'b0;
  localparam logic PAR_TWO = 1'b1;

  typedef struct packed {
    logic               action;
    logic [4:0]         source_index;
    logic               parity_select;
    logic [1:0]         lane;
    logic [WORD_W-1:0]  payload_word;
    logic               last_source;
    logic [COUNT_W-1:0] valid_bytes;
  } in_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] parity_one_word;
    logic [WORD_W-1:0] parity_two_word;
  } out_rsp_t;

  // control that travels with a data request down the pipeline
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [COUNT_W-1:0] count;
  } stage_ctl_t;

endpackage : gfadp_pkg
`default_nettype wire

// ===== sv/gfadp_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfadp_table
// Matrix table: one memory per parity, indexed by {source, lane}. Both
// parity matrices of a data request are read in the same cycle.
// ----------------------------------------------------------------------------
module gfadp_table import gfadp_pkg::*; #(
  parameter int unsigned MAX_SOURCES = 32,
  parameter int unsigned AW          = $clog2(MAX_SOURCES * 4)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic              wr_sel,
  input  wire logic [AW-1:0]     addr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic              rd_en,
  output logic      [WORD_W-1:0] rdata_one,
  output logic      [WORD_W-1:0] rdata_two
);

  localparam int unsigned DEPTH = MAX_SOURCES * 4;

  logic [WORD_W-1:0] mem_one [DEPTH];
  logic [WORD_W-1:0] mem_two [DEPTH];
  logic [WORD_W-1:0] rdata_one_r;
  logic [WORD_W-1:0] rdata_two_r;

  always_ff @(posedge clk) begin
    if (wr_en && (wr_sel == PAR_ONE)) begin
      mem_one[addr] <= wdata;
    end
    if (wr_en && (wr_sel == PAR_TWO)) begin
      mem_two[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_one_r <= mem_one[addr];
      rdata_two_r <= mem_two[addr];
    end
  end

  assign rdata_one = rdata_one_r;
  assign rdata_two = rdata_two_r;

endmodule : gfadp_table
`default_nettype wire

// ===== sv/gfadp_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfadp_lane
// One byte lane: affine bit-matrix transform of a data byte under the
// first-parity and the second-parity matrix.
// ----------------------------------------------------------------------------
module gfadp_lane import gfadp_pkg::*; (
  input  wire logic [WORD_W-1:0] mat_one,
  input  wire logic [WORD_W-1:0] mat_two,
  input  wire logic [7:0]        data_byte,
  output logic      [7:0]        out_one,
  output logic      [7:0]        out_two
);

  localparam logic [7:0] AFFINE_CONST = 8'h00;

  // result bit i is the parity of matrix byte (7-i) AND x
  function automatic logic [7:0] affine_byte(input logic [WORD_W-1:0] mat,
                                             input logic [7:0] x);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[i] = ^(mat[8*(7-i) +: 8] & x);
    end
    return r ^ AFFINE_CONST;
  endfunction

  assign out_one = affine_byte(mat_one, data_byte);
  assign out_two = affine_byte(mat_two, data_byte);

endmodule : gfadp_lane
`default_nettype wire

// ===== sv/gfadp_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfadp_accum
// Merge stage: XOR-accumulate the lane results into both parity words and
// emit the masked words on the final source of a column.
// ----------------------------------------------------------------------------
module gfadp_accum import gfadp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire stage_ctl_t        ctl,
  input  wire logic [WORD_W-1:0] word_one,
  input  wire logic [WORD_W-1:0] word_two,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_rsp_t               out_rsp
);

  logic [WORD_W-1:0] acc_one_r;
  logic [WORD_W-1:0] acc_two_r;
  logic [WORD_W-1:0] sum_one;
  logic [WORD_W-1:0] sum_two;
  logic [WORD_W-1:0] keep_mask;
  logic              out_valid_r;
  out_rsp_t          out_rsp_r;

  // keep bytes below the count; a count of eight or more keeps all
  function automatic logic [WORD_W-1:0] byte_mask(input logic [COUNT_W-1:0] count);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < BYTES_PER_WORD; b++) begin
      m[8*b +: 8] = (COUNT_W'(b) < count) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  assign sum_one   = acc_one_r ^ word_one;
  assign sum_two   = acc_two_r ^ word_two;
  assign keep_mask = byte_mask(ctl.count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_one_r   <= '0;
      acc_two_r   <= '0;
    end else begin
      if (en && ctl.valid && ctl.last) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (en && ctl.valid) begin
        if (ctl.last) begin
          acc_one_r <= '0;
          acc_two_r <= '0;
        end else begin
          acc_one_r <= sum_one;
          acc_two_r <= sum_two;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && ctl.valid && ctl.last) begin
      out_rsp_r.parity_one_word <= sum_one & keep_mask;
      out_rsp_r.parity_two_word <= sum_two & keep_mask;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule : gfadp_accum
`default_nettype wire

// ===== sv/gf256_affine_two_parity_dot_product.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf256_affine_two_parity_dot_product
// A final-source data request passes the s1, s2 and result registers to the output.
// Throughput: one request per cycle unless stalled; table read, eight byte
// lanes and the accumulator each take one pipeline stage.
// The input stalls only while a result waits and another one is ready behind it.
// Reset (rst_n, synchronous) clears pipeline valids and both accumulators;
// the matrix table is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module gf256_affine_two_parity_dot_product import gfadp_pkg::*; #(
  parameter int unsigned MAX_SOURCES = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_req,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_rsp_t      out_rsp
);

  localparam int unsigned AW      = $clog2(MAX_SOURCES * 4);
  localparam logic [7:0]  MAX_SRC = 8'(MAX_SOURCES);

  logic              en;
  logic              in_accept;
  logic              src_ok;
  logic [AW-1:0]     tbl_addr;
  logic [WORD_W-1:0] rdata_one;
  logic [WORD_W-1:0] rdata_two;
  logic [WORD_W-1:0] mat_one;
  logic [WORD_W-1:0] mat_two;
  logic [WORD_W-1:0] lane_one;
  logic [WORD_W-1:0] lane_two;

  stage_ctl_t        s1_ctl_r;
  stage_ctl_t        s1_ctl_nxt;
  logic              s1_src_ok_r;
  logic [WORD_W-1:0] s1_payload_r;
  stage_ctl_t        s2_ctl_r;
  logic [WORD_W-1:0] s2_one_r;
  logic [WORD_W-1:0] s2_two_r;

  // hold the pipe only when a new result would overrun the waiting one
  assign en        = !(out_valid && out_stall && s2_ctl_r.valid && s2_ctl_r.last);
  assign in_stall  = !en;
  assign in_accept = in_valid && en;
  assign src_ok    = ({3'b000, in_req.source_index} < MAX_SRC);
  assign tbl_addr  = AW'({in_req.source_index, in_req.lane});

  gfadp_table #(
    .MAX_SOURCES (MAX_SOURCES),
    .AW          (AW)
  ) u_table (
    .clk       (clk),
    .wr_en     (in_accept && (in_req.action == ACT_TABLE_WRITE) && src_ok),
    .wr_sel    (in_req.parity_select),
    .addr      (tbl_addr),
    .wdata     (in_req.payload_word),
    .rd_en     (en),
    .rdata_one (rdata_one),
    .rdata_two (rdata_two)
  );

  always_comb begin
    s1_ctl_nxt.valid = in_accept && (in_req.action == ACT_DATA);
    s1_ctl_nxt.last  = in_req.last_source;
    s1_ctl_nxt.count = in_req.valid_bytes;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r <= s1_ctl_nxt;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_src_ok_r  <= src_ok;
      s1_payload_r <= in_req.payload_word;
      s2_one_r     <= lane_one;
      s2_two_r     <= lane_two;
    end
  end

  // sources past the table contribute nothing
  assign mat_one = s1_src_ok_r ? rdata_one : '0;
  assign mat_two = s1_src_ok_r ? rdata_two : '0;

  for (genvar g = 0; g < BYTES_PER_WORD; g++) begin : g_lane
    gfadp_lane u_lane (
      .mat_one   (mat_one),
      .mat_two   (mat_two),
      .data_byte (s1_payload_r[8*g +: 8]),
      .out_one   (lane_one[8*g +: 8]),
      .out_two   (lane_two[8*g +: 8])
    );
  end

  gfadp_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl       (s2_ctl_r),
    .word_one  (s2_one_r),
    .word_two  (s2_two_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_write_no_data : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_req.action == ACT_TABLE_WRITE)) |=> !s1_ctl_r.valid)
    else $error("table write entered the data pipeline");

  a_last_emits : assert property (@(posedge clk) disable iff (!rst_n)
    (en && s2_ctl_r.valid && s2_ctl_r.last) |=> out_valid)
    else $error("final source did not produce a result");

endmodule : gf256_affine_two_parity_dot_product
`default_nettype wire

// ===== tb/gfadp_parity_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfadp_parity_checker
// Watches both channels of the two-parity dot-product engine, keeps a shadow
// matrix table and both accumulators, and checks every accepted result
// against the oldest predicted parity pair.
// ----------------------------------------------------------------------------
module gfadp_parity_checker import gfadp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_req_t  in_req,
  input  logic     out_valid,
  input  logic     out_stall,
  input  out_rsp_t out_rsp,
  output int       fail_count,
  output int       pending
);

  logic [WORD_W-1:0] matrix_mem [0:255];
  logic [WORD_W-1:0] acc_one;
  logic [WORD_W-1:0] acc_two;
  out_rsp_t          parity_due_q [$];
  int                errs = 0;

  // Output bit i of each byte is the parity of matrix byte (7-i) AND the
  // source byte; the affine constant is zero.
  function automatic logic [WORD_W-1:0] gf_affine_word(input logic [WORD_W-1:0] mat,
                                                       input logic [WORD_W-1:0] data);
    logic [WORD_W-1:0] res;
    res = '0;
    for (int b = 0; b < BYTES_PER_WORD; b++) begin
      for (int i = 0; i < 8; i++) begin
        res[8*b + i] = ^(mat[8*(7-i) +: 8] & data[8*b +: 8]);
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_rsp_t          due;
    logic [WORD_W-1:0] mask;
    if (!rst_n) begin
      acc_one = '0;
      acc_two = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parity_due_q.size() == 0) begin
          errs++;
          $error("unexpected result: parity_one_word %h parity_two_word %h",
                 out_rsp.parity_one_word, out_rsp.parity_two_word);
        end else begin
          due = parity_due_q.pop_front();
          if (out_rsp.parity_one_word !== due.parity_one_word) begin
            errs++;
            $error("parity_one_word: expected %h, got %h",
                   due.parity_one_word, out_rsp.parity_one_word);
          end
          if (out_rsp.parity_two_word !== due.parity_two_word) begin
            errs++;
            $error("parity_two_word: expected %h, got %h",
                   due.parity_two_word, out_rsp.parity_two_word);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_req.action == ACT_TABLE_WRITE) begin
          matrix_mem[{in_req.source_index, in_req.parity_select, in_req.lane}] =
            in_req.payload_word;
        end else begin
          acc_one ^= gf_affine_word(matrix_mem[{in_req.source_index, PAR_ONE, in_req.lane}],
                                    in_req.payload_word);
          acc_two ^= gf_affine_word(matrix_mem[{in_req.source_index, PAR_TWO, in_req.lane}],
                                    in_req.payload_word);
          if (in_req.last_source) begin
            // zero the tail bytes; counts of eight and above keep all bytes
            if (in_req.valid_bytes >= BYTES_PER_WORD)
              mask = '1;
            else
              mask = (64'h1 << (8 * in_req.valid_bytes)) - 64'h1;
            due.parity_one_word = acc_one & mask;
            due.parity_two_word = acc_two & mask;
            parity_due_q.push_back(due);
            acc_one = '0;
            acc_two = '0;
          end
        end
      end
    end
    fail_count <= errs;
    pending    <= parity_due_q.size();
  end

endmodule : gfadp_parity_checker

// ===== tb/gf256_affine_two_parity_dot_product_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_affine_two_parity_dot_product_tb
// Loads matrix words, then streams directed and random parity columns into
// the engine with random gaps and output stalls, one long output hold-off
// and a full drain in the middle; the checker predicts and compares.
// ----------------------------------------------------------------------------
module gf256_affine_two_parity_dot_product_tb;
  import gfadp_pkg::*;

  localparam logic [WORD_W-1:0] IDENT_MATRIX = 64'h0102040810204080;
  localparam int ITEM_TARGET  = 700;
  localparam int HOLD_CYCLES  = 150;
  localparam int TAIL_CYCLES  = 12;
  localparam int CYCLE_LIMIT  = 200000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_rsp_t out_rsp;
  int       fail_count;
  int       pending;

  int       req_count   = 0;
  int       cycle_count = 0;
  bit       idle_on     = 1'b1;
  bit       hold_req    = 1'b0;
  bit       hold_done   = 1'b0;
  bit       loaded [0:255];

  gf256_affine_two_parity_dot_product u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  gfadp_parity_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] rand_matrix();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return IDENT_MATRIX;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    if ($urandom_range(0, 3) != 0)
      return COUNT_W'($urandom_range(1, 8));
    return COUNT_W'($urandom_range(0, 15));
  endfunction

  // hold the request until accepted
  task automatic send_req(input in_req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    req_count++;
  endtask

  task automatic load_matrix(input logic [4:0] src, input logic par,
                             input logic [1:0] ln, input logic [WORD_W-1:0] word);
    in_req_t r;
    r.action        = ACT_TABLE_WRITE;
    r.source_index  = src;
    r.parity_select = par;
    r.lane          = ln;
    r.payload_word  = word;
    r.last_source   = 1'($urandom_range(0, 1));
    r.valid_bytes   = COUNT_W'($urandom_range(0, 15));
    send_req(r);
    loaded[{src, par, ln}] = 1'b1;
  endtask

  // never read a table entry that was not written
  task automatic send_data(input logic [4:0] src, input logic [1:0] ln,
                           input logic [WORD_W-1:0] word, input logic last,
                           input logic [COUNT_W-1:0] cnt);
    in_req_t r;
    if (!loaded[{src, PAR_ONE, ln}]) load_matrix(src, PAR_ONE, ln, rand_matrix());
    if (!loaded[{src, PAR_TWO, ln}]) load_matrix(src, PAR_TWO, ln, rand_matrix());
    r.action        = ACT_DATA;
    r.source_index  = src;
    r.parity_select = 1'($urandom_range(0, 1));
    r.lane          = ln;
    r.payload_word  = word;
    r.last_source   = last;
    r.valid_bytes   = cnt;
    send_req(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stall per result, one long hold-off when asked
  initial begin
    int gap;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      gap = idle_on ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int          kind;
    int          nsrc;
    bit          pressure_done;
    logic [1:0]  col_lane;
    pressure_done = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extreme matrices, sources, lanes and byte counts
    load_matrix(5'd0,  PAR_ONE, 2'd0, IDENT_MATRIX);
    load_matrix(5'd0,  PAR_TWO, 2'd0, '1);
    load_matrix(5'd31, PAR_ONE, 2'd3, '0);
    load_matrix(5'd31, PAR_TWO, 2'd3, IDENT_MATRIX);
    send_data(5'd0,  2'd0, '1, 1'b1, 4'd8);
    send_data(5'd0,  2'd0, '0, 1'b1, 4'd1);
    send_data(5'd0,  2'd0, 64'h0123456789abcdef, 1'b0, 4'd15);
    send_data(5'd31, 2'd3, 64'hfedcba9876543210, 1'b1, 4'd15);
    send_data(5'd31, 2'd3, '1, 1'b1, 4'd0);
    send_data(5'd0,  2'd0, {$urandom, $urandom}, 1'b1, 4'd9);
    // rewrite a matrix in the middle of a column
    send_data(5'd0,  2'd0, {$urandom, $urandom}, 1'b0, 4'd3);
    load_matrix(5'd0, PAR_ONE, 2'd0, rand_matrix());
    send_data(5'd31, 2'd3, {$urandom, $urandom}, 1'b0, 4'd0);
    send_data(5'd0,  2'd0, {$urandom, $urandom}, 1'b1, 4'd7);
    send_data(5'd10, 2'd1, 64'h8000000000000001, 1'b1, 4'd1);
    send_data(5'd21, 2'd2, 64'h00ff00ff00ff00ff, 1'b1, 4'd2);

    while (req_count < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) idle_on = !idle_on;
      if (!pressure_done && req_count >= ITEM_TARGET / 2) begin
        // fill the pipe behind a stalled receiver, then pause until drained
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (24) send_data(5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)),
                              {$urandom, $urandom}, 1'b1, pick_count());
        drain();
        idle_on       = 1'b1;
        pressure_done = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        load_matrix(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                    2'($urandom_range(0, 3)), rand_matrix());
      end else if (kind == 1) begin
        // broken column: partial words, carried into the next column
        repeat ($urandom_range(1, 3))
          send_data(5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)),
                    {$urandom, $urandom}, 1'b0, pick_count());
      end else begin
        nsrc     = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 32) : $urandom_range(1, 4);
        col_lane = 2'($urandom_range(0, 3));
        for (int j = 0; j < nsrc; j++) begin
          if ($urandom_range(0, 19) == 0)
            load_matrix(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), col_lane,
                        rand_matrix());
          send_data(5'($urandom_range(0, 31)), col_lane, {$urandom, $urandom},
                    j == nsrc - 1, pick_count());
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule : gf256_affine_two_parity_dot_product_tb

// ===== gf256_affine_two_parity_dot_product.f =====
sv/gfadp_pkg.sv
sv/gfadp_table.sv
sv/gfadp_lane.sv
sv/gfadp_accum.sv
sv/gf256_affine_two_parity_dot_product.sv
tb/gfadp_parity_checker.sv
tb/gf256_affine_two_parity_dot_product_tb.sv
